/* rtl/tlfd_pkg.sv */
package tlfd_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int POS_W        = 2;
   localparam int LEN_W        = 32;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BYTES - 1);

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd1048576;

   localparam logic [7:0] STREAM_TAG [HEADER_BYTES] = '{8'h53, 8'h4E, 8'h44, 8'h52};
   localparam logic [7:0] DICT_TAG   [HEADER_BYTES] = '{8'h4C, 8'h44, 8'h49, 8'h43};

   localparam logic FT_STREAM = 1'b0;
   localparam logic FT_DICT   = 1'b1;

   typedef enum logic [3:0] {
      PH_TAG  = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_ERR  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD     = 2'd0,
      EV_EMPTY       = 2'd1,
      EV_UNKNOWN_TAG = 2'd2,
      EV_TOO_LONG    = 2'd3
   } event_kind_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [7:0]     payload_byte;
      logic           frame_type;
      logic           last_of_frame;
   } rsp_word_type;

   typedef struct packed {
      logic         hit;
      rsp_word_type word;
   } parser_result_type;

endpackage

/* rtl/tlfd_if.sv */
interface tlfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tlfd_rsp_if;
   import tlfd_pkg::*;

   logic           valid;
   logic           ready;
   event_kind_type event_kind;
   logic [7:0]     payload_byte;
   logic           frame_type;
   logic           last_of_frame;

   modport source (output valid, output event_kind, output payload_byte,
                   output frame_type, output last_of_frame, input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input frame_type, input last_of_frame, output ready);
endinterface

interface tlfd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tagged_length_frame_deframer_core.sv */
// Splits a byte stream of tagged frames (four tag bytes, a four-byte little-endian length,
// then the payload) into one word per payload byte carrying its frame type and a last flag,
// an empty-frame word for a zero length, and an error word for an unknown tag or a length
// above the configured maximum; after an error every further byte is swallowed until reset.
// The block takes one byte per cycle while the output is not stalled; each accepted byte
// is held in the input register and its result in the output register. This rate is set
// by the parser's frame state update, which sits between them. The configuration channel is
// always ready and should be written only while no byte is in flight.
module tagged_length_frame_deframer_core (
   input  logic         clock,
   input  logic         reset,
   tlfd_req_if.sink     req_if,
   tlfd_rsp_if.source   rsp_if,
   tlfd_csr_if.sink     csr_if
);
   import tlfd_pkg::*;

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;
   logic [LEN_W-1:0]  max_len_ff;

   logic              out_free;
   logic              step;
   parser_result_type result;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || step;
   assign csr_if.ready = 1'b1;

   tlfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (in_byte_ff),
      .max_len     (max_len_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= step && result.hit;
         end
         if (csr_if.valid) begin
            max_len_ff <= csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.stream_byte;
      end
      if (step && result.hit) begin
         rsp_word_ff <= result.word;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.event_kind    = rsp_word_ff.event_kind;
   assign rsp_if.payload_byte  = rsp_word_ff.payload_byte;
   assign rsp_if.frame_type    = rsp_word_ff.frame_type;
   assign rsp_if.last_of_frame = rsp_word_ff.last_of_frame;

endmodule

/* rtl/tlfd_parser.sv */
module tlfd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    stream_byte,
   input  logic [tlfd_pkg::LEN_W-1:0]    max_len,
   output tlfd_pkg::parser_result_type   result
);
   import tlfd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             stream_ok_ff, stream_ok_in;
   logic             dict_ok_ff, dict_ok_in;
   logic             type_ff, type_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] remain_ff, remain_in;

   logic             match_stream;
   logic             match_dict;
   logic             last_pos;
   logic [LEN_W-1:0] full_len;

   assign match_stream = stream_ok_ff && (stream_byte == STREAM_TAG[pos_ff]);
   assign match_dict   = dict_ok_ff && (stream_byte == DICT_TAG[pos_ff]);
   assign last_pos     = (pos_ff == LAST_POS);
   assign full_len     = {stream_byte, len_ff[LEN_W-9:0]};

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      stream_ok_in = stream_ok_ff;
      dict_ok_in   = dict_ok_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      remain_in    = remain_ff;

      result.hit                = 1'b0;
      result.word.event_kind    = EV_PAYLOAD;
      result.word.payload_byte  = 8'h00;
      result.word.frame_type    = type_ff;
      result.word.last_of_frame = 1'b0;

      if (step) begin
         case (phase_ff)
            PH_TAG: begin
               stream_ok_in = match_stream;
               dict_ok_in   = match_dict;
               if (!last_pos) begin
                  pos_in = pos_ff + 1'b1;
               end else begin
                  pos_in = '0;
                  if (match_stream || match_dict) begin
                     type_in  = match_stream ? FT_STREAM : FT_DICT;
                     phase_in = PH_LEN;
                     len_in   = '0;
                  end else begin
                     phase_in                = PH_ERR;
                     result.hit              = 1'b1;
                     result.word.event_kind  = EV_UNKNOWN_TAG;
                     result.word.frame_type  = FT_STREAM;
                  end
               end
            end
            PH_LEN: begin
               len_in[8*pos_ff +: 8] = stream_byte;
               if (!last_pos) begin
                  pos_in = pos_ff + 1'b1;
               end else begin
                  pos_in = '0;
                  if (full_len > max_len) begin
                     phase_in               = PH_ERR;
                     result.hit             = 1'b1;
                     result.word.event_kind = EV_TOO_LONG;
                  end else if (full_len == '0) begin
                     phase_in                  = PH_TAG;
                     stream_ok_in              = 1'b1;
                     dict_ok_in                = 1'b1;
                     result.hit                = 1'b1;
                     result.word.event_kind    = EV_EMPTY;
                     result.word.last_of_frame = 1'b1;
                  end else begin
                     remain_in = full_len;
                     phase_in  = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               remain_in                = remain_ff - 1'b1;
               result.hit               = 1'b1;
               result.word.payload_byte = stream_byte;
               if (remain_ff == LEN_W'(1)) begin
                  phase_in                  = PH_TAG;
                  stream_ok_in              = 1'b1;
                  dict_ok_in                = 1'b1;
                  result.word.last_of_frame = 1'b1;
               end
            end
            PH_ERR: begin
               phase_in = PH_ERR;
            end
            default: begin
               phase_in = PH_ERR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         pos_ff       <= '0;
         stream_ok_ff <= 1'b1;
         dict_ok_ff   <= 1'b1;
         type_ff      <= FT_STREAM;
         len_ff       <= '0;
         remain_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         stream_ok_ff <= stream_ok_in;
         dict_ok_ff   <= dict_ok_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         remain_ff    <= remain_in;
      end
   end

endmodule

/* rtl/tlfd_checker.sv */
module tlfd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tlfd_pkg::event_kind_type rsp_event_kind,
   input logic [7:0]               rsp_payload_byte,
   input logic                     rsp_frame_type,
   input logic                     rsp_last_of_frame
);
   import tlfd_pkg::*;

   // A result that is held back must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_frame_type)
         && $stable(rsp_last_of_frame))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // Only payload words carry a byte; an unknown tag word carries the stream type and no last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != EV_PAYLOAD) |-> rsp_payload_byte == 8'h00)
      else $error("non-payload word carries a byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_UNKNOWN_TAG)
         |-> (rsp_frame_type == FT_STREAM) && !rsp_last_of_frame)
      else $error("unknown tag word has wrong flags");

   // Once an error word is taken the block stays silent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready
         && ((rsp_event_kind == EV_UNKNOWN_TAG) || (rsp_event_kind == EV_TOO_LONG))
         |=> !rsp_valid)
      else $error("result after an error word");

endmodule

bind tagged_length_frame_deframer_core tlfd_checker u_tlfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_event_kind    (rsp_if.event_kind),
   .rsp_payload_byte  (rsp_if.payload_byte),
   .rsp_frame_type    (rsp_if.frame_type),
   .rsp_last_of_frame (rsp_if.last_of_frame)
);

/* tb/tb_top.sv */
module tb_top;
   import tlfd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned REPORT_LIMIT = 200;
   localparam int unsigned IDLE_PCT     = 26;

   localparam rsp_word_type NO_WORD = '0;

   typedef struct {
      logic [7:0]   b;
      bit           typed;
      bit           has;
      rsp_word_type word;
      bit           wr;
      logic [31:0]  wr_val;
   } byte_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlfd_req_if req_if ();
   tlfd_rsp_if rsp_if ();
   tlfd_csr_if csr_if ();

   tagged_length_frame_deframer_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   byte_row_type pending_bytes [$];
   rsp_word_type expected_words [$];
   byte_row_type byte_on_bus;
   int unsigned  bytes_queued   = 0;
   int unsigned  bytes_accepted = 0;
   int unsigned  bad_words      = 0;
   int unsigned  cycles         = 0;
   bit           no_idle        = 1'b0;

   phase_type   dfr_phase;
   logic [1:0]  hdr_pos;
   logic        maybe_stream;
   logic        maybe_dict;
   logic        cur_type;
   logic [31:0] len_acc;
   logic [31:0] payload_left;
   logic [31:0] max_length;

   function automatic void arm_tag_search();
      dfr_phase    = PH_TAG;
      hdr_pos      = '0;
      maybe_stream = 1'b1;
      maybe_dict   = 1'b1;
   endfunction

   function automatic void reset_deframer();
      max_length   = MAX_LEN_RESET;
      cur_type     = FT_STREAM;
      len_acc      = '0;
      payload_left = '0;
      arm_tag_search();
   endfunction

   function automatic void deframe_byte(input logic [7:0] b, output bit has,
                                        output rsp_word_type word);
      has  = 1'b0;
      word = NO_WORD;
      case (dfr_phase)
         PH_TAG: begin
            if (b != STREAM_TAG[hdr_pos]) maybe_stream = 1'b0;
            if (b != DICT_TAG[hdr_pos]) maybe_dict = 1'b0;
            if (hdr_pos != LAST_POS) begin
               hdr_pos++;
            end else if (maybe_stream || maybe_dict) begin
               hdr_pos   = '0;
               cur_type  = maybe_stream ? FT_STREAM : FT_DICT;
               len_acc   = '0;
               dfr_phase = PH_LEN;
            end else begin
               hdr_pos   = '0;
               dfr_phase = PH_ERR;
               has       = 1'b1;
               word      = '{EV_UNKNOWN_TAG, 8'h00, FT_STREAM, 1'b0};
            end
         end
         PH_LEN: begin
            len_acc[8*hdr_pos +: 8] = b;
            if (hdr_pos != LAST_POS) begin
               hdr_pos++;
            end else begin
               hdr_pos = '0;
               has     = 1'b1;
               if (len_acc > max_length) begin
                  dfr_phase = PH_ERR;
                  word      = '{EV_TOO_LONG, 8'h00, cur_type, 1'b0};
               end else if (len_acc == 0) begin
                  arm_tag_search();
                  word = '{EV_EMPTY, 8'h00, cur_type, 1'b1};
               end else begin
                  has          = 1'b0;
                  payload_left = len_acc;
                  dfr_phase    = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            payload_left--;
            has  = 1'b1;
            word = '{EV_PAYLOAD, b, cur_type, payload_left == 0};
            if (payload_left == 0) arm_tag_search();
         end
         default: begin
         end
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back('{b, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0});
      bytes_queued++;
   endtask

   task automatic queue_frame(input bit dict, input logic [31:0] len,
                              input int unsigned body);
      for (int i = 0; i < HEADER_BYTES; i++) push_byte(dict ? DICT_TAG[i] : STREAM_TAG[i]);
      for (int i = 0; i < HEADER_BYTES; i++) push_byte(len[8*i +: 8]);
      for (int unsigned i = 0; i < body; i++) push_byte(8'($urandom));
   endtask

   task automatic queue_random_frames(input int unsigned budget, input logic [31:0] cap);
      int unsigned stop_at;
      int unsigned pick;
      logic [31:0] len;
      stop_at = bytes_queued + budget;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) len = cap;
         else if (pick == 1) len = $urandom_range(0, cap);
         else len = $urandom_range(0, cap < 12 ? cap : 12);
         queue_frame(1'($urandom_range(0, 1)), len, len);
      end
   endtask

   task automatic wait_drained();
      while (bytes_accepted != bytes_queued || expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [31:0] value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      max_length = value;
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         bad_words++;
         if (bad_words <= REPORT_LIMIT)
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : drive_bytes
      bit           has;
      rsp_word_type word;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            deframe_byte(byte_on_bus.b, has, word);
            if (byte_on_bus.typed) begin
               has  = byte_on_bus.has;
               word = byte_on_bus.word;
            end
            if (has) expected_words.push_back(word);
            bytes_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_bytes.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
               byte_on_bus = pending_bytes.pop_front();
               req_if.valid       <= 1'b1;
               req_if.stream_byte <= byte_on_bus.b;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               bad_words++;
               if (bad_words <= REPORT_LIMIT)
                  $display("%0t: expected no word, actual kind %0d byte %0h type %0b last %0b",
                           $time, rsp_if.event_kind, rsp_if.payload_byte, rsp_if.frame_type,
                           rsp_if.last_of_frame);
            end else begin
               want = expected_words.pop_front();
               check_field("event_kind", 8'(want.event_kind), 8'(rsp_if.event_kind));
               check_field("payload_byte", want.payload_byte, rsp_if.payload_byte);
               check_field("frame_type", 8'(want.frame_type), 8'(rsp_if.frame_type));
               check_field("last_of_frame", 8'(want.last_of_frame), 8'(rsp_if.last_of_frame));
            end
         end
         rsp_if.ready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : run
      byte_row_type directed [27];
      logic [31:0]  small_max;
      logic [31:0]  final_max;
      logic [31:0]  final_len;
      logic [7:0]   tag_byte;
      bit           dict;
      int unsigned  bad_pos;
      reset_deframer();
      req_if.valid       = 1'b0;
      req_if.stream_byte = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.data        = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // An empty stream frame and a two-byte dictionary frame under the reset maximum,
      // then a stream frame whose maximum is lowered to one between tag and length.
      directed = '{
         '{8'h53, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h4E, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h44, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h52, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b1, 1'b1, '{EV_EMPTY, 8'h00, FT_STREAM, 1'b1}, 1'b0, 32'd0},
         '{8'h4C, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h44, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h49, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h43, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h02, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b1, 1'b1, '{EV_PAYLOAD, 8'h00, FT_DICT, 1'b0}, 1'b0, 32'd0},
         '{8'hFF, 1'b1, 1'b1, '{EV_PAYLOAD, 8'hFF, FT_DICT, 1'b1}, 1'b0, 32'd0},
         '{8'h53, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h4E, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h44, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h52, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h01, 1'b0, 1'b0, NO_WORD, 1'b1, 32'd1},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'h00, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0},
         '{8'hA5, 1'b0, 1'b0, NO_WORD, 1'b0, 32'd0}
      };
      foreach (directed[i]) begin
         if (directed[i].wr) write_max_length(directed[i].wr_val);
         pending_bytes.push_back(directed[i]);
         bytes_queued++;
      end

      queue_random_frames(250, 32'd1);
      write_max_length(32'd0);
      queue_random_frames(80, 32'd0);
      write_max_length(32'hFFFF_FFFF);
      no_idle = 1'b1;
      queue_random_frames(300, 32'd40);
      wait_drained();
      no_idle = 1'b0;
      small_max = $urandom_range(2, 40);
      write_max_length(small_max);
      queue_random_frames(300, small_max);
      write_max_length(MAX_LEN_RESET);
      queue_random_frames(150, 32'd40);

      // Both errors are sticky until reset, so the run closes with one of them.
      dict = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) begin
         final_max = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFE : $urandom_range(0, 200);
         if (final_max == 32'hFFFF_FFFE || $urandom_range(0, 1) == 1) final_len = 32'hFFFF_FFFF;
         else final_len = final_max + 1 + $urandom_range(0, 1000);
         write_max_length(final_max);
         queue_frame(dict, final_len, 0);
      end else begin
         bad_pos = $urandom_range(0, HEADER_BYTES - 1);
         for (int i = 0; i < HEADER_BYTES; i++) begin
            tag_byte = dict ? DICT_TAG[i] : STREAM_TAG[i];
            if (i == bad_pos) tag_byte ^= 8'($urandom_range(1, 255));
            push_byte(tag_byte);
         end
      end
      for (int i = 0; i < 3; i++) queue_frame(1'($urandom_range(0, 1)), 32'd2, 2);
      for (int i = 0; i < 10; i++) push_byte(8'($urandom));

      wait_drained();
      repeat (4) @(posedge clock);
      if (bad_words == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
